@@ hw/rtl/dspk_pkg.sv @@
// Shared types and constants of the display SPI nine-bit packer.
package dspk_pkg;

  // Widths of the word fields.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CfgIdxW   = 2;

  // Buffer depth; one input byte yields at most two SPI bytes, padded tail included.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CountW     = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDcPinUsed = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCsPinUsed = 2'd1;

  typedef struct packed {
    logic dc_pin_used;
    logic cs_pin_used;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] spi_byte;
    logic             dc_level;
    logic             cs_pulse_after;
    logic             last_result;
  } result_t;

endpackage

@@ hw/rtl/dspk_if.sv @@
// Handshake channels of the packer: input words, SPI byte words and register writes.
interface dspk_in_if;
  logic                            valid;
  logic                            ready;
  logic [dspk_pkg::ByteW-1:0]      payload_byte;
  logic                            is_data;
  logic                            toggle_cs_each;
  logic                            end_of_run;

  modport source (output valid, payload_byte, is_data, toggle_cs_each, end_of_run,
                  input ready);
  modport sink   (input valid, payload_byte, is_data, toggle_cs_each, end_of_run,
                  output ready);
endinterface

interface dspk_out_if;
  logic                            valid;
  logic                            ready;
  logic [dspk_pkg::ByteW-1:0]      spi_byte;
  logic                            dc_level;
  logic                            cs_pulse_after;
  logic                            last_result;

  modport source (output valid, spi_byte, dc_level, cs_pulse_after, last_result,
                  input ready);
  modport sink   (input valid, spi_byte, dc_level, cs_pulse_after, last_result,
                  output ready);
endinterface

interface dspk_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dspk_pkg::CfgIdxW-1:0]    index;
  logic                            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dspk_frame.sv @@
// Combinational framing of one input byte into up to two SPI byte results.
module dspk_frame (
  input  dspk_pkg::cfg_t                         cfg_i,
  input  logic [dspk_pkg::ByteW-1:0]             payload_byte_i,
  input  logic                                   is_data_i,
  input  logic                                   toggle_cs_each_i,
  input  logic                                   end_of_run_i,
  input  logic [dspk_pkg::PhaseW-1:0]            phase_i,
  input  logic [dspk_pkg::ByteW-1:0]             held_i,
  output dspk_pkg::result_t                      res_o [dspk_pkg::MaxResults],
  output logic [dspk_pkg::CountW-1:0]            count_o,
  output logic [dspk_pkg::PhaseW-1:0]            phase_o,
  output logic [dspk_pkg::ByteW-1:0]             held_o
);

  logic [dspk_pkg::PhaseW-1:0]      ph;
  logic [2*dspk_pkg::ByteW:0]       stream;
  logic [2*dspk_pkg::ByteW:0]       stream_sh;
  logic [2*dspk_pkg::ByteW-1:0]     tail;
  logic [2*dspk_pkg::ByteW-1:0]     tail_sh;

  // The held byte, the flag bit and the new byte form one bit stream; the phase picks a window.
  assign ph        = phase_i + 3'd1;
  assign stream    = {held_i, is_data_i, payload_byte_i};
  assign stream_sh = stream >> ph;
  assign tail      = {payload_byte_i, 8'd0};
  assign tail_sh   = tail >> ph;

  always_comb begin
    res_o[0] = '0;
    res_o[1] = '0;
    res_o[2] = '0;
    count_o  = '0;
    phase_o  = '0;
    held_o   = '0;
    if (cfg_i.dc_pin_used) begin
      // Four-wire mode: the byte passes through and any partial run is dropped.
      res_o[0].spi_byte       = payload_byte_i;
      res_o[0].dc_level       = is_data_i;
      res_o[0].cs_pulse_after = toggle_cs_each_i & cfg_i.cs_pin_used;
      res_o[0].last_result    = 1'b1;
      count_o                 = 2'd1;
    end else begin
      // Three-wire mode: nine-bit frames packed into SPI bytes.
      if (ph == '0) begin
        res_o[0].spi_byte = stream[2*dspk_pkg::ByteW-1:dspk_pkg::ByteW];
        res_o[1].spi_byte = payload_byte_i;
        count_o           = 2'd2;
      end else begin
        res_o[0].spi_byte = stream_sh[dspk_pkg::ByteW-1:0];
        count_o           = 2'd1;
      end
      if (end_of_run_i) begin
        // Leftover bits go out zero padded, with a chip-select pulse if chip select is present.
        if (ph != '0) begin
          res_o[1].spi_byte       = tail_sh[dspk_pkg::ByteW-1:0];
          res_o[1].cs_pulse_after = cfg_i.cs_pin_used;
          count_o                 = 2'd2;
        end
      end else begin
        phase_o = ph;
        held_o  = payload_byte_i;
      end
      res_o[count_o - 2'd1].last_result = 1'b1;
    end
  end

endmodule

@@ hw/rtl/display_spi_nine_bit_packer.sv @@
// Top level of the display SPI nine-bit packer: state, result buffer and handshakes.
//
// Usage:
//   in_i takes one payload byte per word with its data/command flag, the
//   per-byte chip-select request and the end-of-run mark. out_o delivers SPI
//   bytes with the data/command level, the chip-select pulse request and a
//   mark on the last byte caused by each input word. cfg_i writes the two
//   registers (index 0: data/command pin present, index 1: chip select present)
//   and is always ready; write it only while the block is idle.
// Output: a result word is registered and offered in the cycle after its input is taken.
// Throughput: one input word per cycle while each word yields one SPI byte
//   and out_o is ready; a word that yields two bytes holds the input until
//   its second byte leaves, as the result buffer drains one byte per cycle.
// Reset: both registers come up as 1 (four-wire mode, chip select present),
//   the bit phase and held byte clear and the result buffer is empty.
// Stall: while out_o is not ready the current byte holds; a new input word is
//   taken only while the buffer is empty or in the cycle its last byte leaves.
module display_spi_nine_bit_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  dspk_in_if.sink           in_i,
  dspk_out_if.source        out_o,
  dspk_cfg_if.sink          cfg_i
);

  dspk_pkg::cfg_t                     cfg_q;
  logic [dspk_pkg::PhaseW-1:0]        phase_q;
  logic [dspk_pkg::PhaseW-1:0]        phase_d;
  logic [dspk_pkg::ByteW-1:0]         held_q;
  logic [dspk_pkg::ByteW-1:0]         held_d;
  dspk_pkg::result_t                  res_q [dspk_pkg::MaxResults];
  dspk_pkg::result_t                  res_d [dspk_pkg::MaxResults];
  logic [dspk_pkg::CountW-1:0]        cnt_q;
  logic [dspk_pkg::CountW-1:0]        cnt_d;
  logic [dspk_pkg::CountW-1:0]        rd_idx_q;
  dspk_pkg::result_t                  cur;
  logic                               in_fire;
  logic                               out_fire;
  logic                               draining_last;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dc_pin_used: 1'b1, cs_pin_used: 1'b1};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dspk_pkg::CfgDcPinUsed: cfg_q.dc_pin_used <= cfg_i.data;
        dspk_pkg::CfgCsPinUsed: cfg_q.cs_pin_used <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Framing of the incoming word against the packing state.
  dspk_frame u_frame (
    .cfg_i            (cfg_q),
    .payload_byte_i   (in_i.payload_byte),
    .is_data_i        (in_i.is_data),
    .toggle_cs_each_i (in_i.toggle_cs_each),
    .end_of_run_i     (in_i.end_of_run),
    .phase_i          (phase_q),
    .held_i           (held_q),
    .res_o            (res_d),
    .count_o          (cnt_d),
    .phase_o          (phase_d),
    .held_o           (held_d)
  );

  // Handshake: the buffer refills in the same cycle its last byte leaves.
  assign cur           = res_q[rd_idx_q];
  assign out_fire      = out_o.valid && out_o.ready;
  assign draining_last = out_fire && (rd_idx_q == cnt_q - 2'd1);
  assign in_i.ready    = (cnt_q == '0) || draining_last;
  assign in_fire       = in_i.valid && in_i.ready;

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.spi_byte       = cur.spi_byte;
  assign out_o.dc_level       = cur.dc_level;
  assign out_o.cs_pulse_after = cur.cs_pulse_after;
  assign out_o.last_result    = cur.last_result;

  // Packing state and buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      held_q   <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= '0;
    end else if (draining_last) begin
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else if (out_fire) begin
      rd_idx_q <= rd_idx_q + 2'd1;
    end
  end

  // Result words need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // The read pointer always stays inside the filled part of the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (rd_idx_q < cnt_q))
    else $error("read pointer beyond buffered results");

  // The byte on offer carries the last mark exactly when it is the buffer's final entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_result == (rd_idx_q == cnt_q - 2'd1)))
    else $error("last mark does not match buffer position");

  // A new word is taken while bytes are pending only as the final one leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cnt_q != '0) |-> draining_last)
    else $error("input accepted over pending results");

  // Three-wire mode never drives the data/command level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_q.dc_pin_used) |=> !out_o.dc_level)
    else $error("data/command level set in three-wire mode");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the display SPI nine-bit packer with its own packing predictor.
module tb;

  // Register indexes beyond the two defined ones; writes to them must be ignored.
  localparam logic [dspk_pkg::CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [dspk_pkg::CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongHold    = 120;
  localparam int unsigned QuietCycles = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 34;

  typedef struct packed {
    logic [dspk_pkg::ByteW-1:0] payload_byte;
    logic                       is_data;
    logic                       toggle_cs_each;
    logic                       end_of_run;
  } in_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dspk_in_if  in_ch ();
  dspk_out_if out_ch ();
  dspk_cfg_if cfg_ch ();

  display_spi_nine_bit_packer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Predictor state: register copies, packing phase and the byte held for the next SPI byte.
  dspk_pkg::cfg_t              model_cfg  = '{dc_pin_used: 1'b1, cs_pin_used: 1'b1};
  logic [dspk_pkg::PhaseW-1:0] pack_phase = '0;
  logic [dspk_pkg::ByteW-1:0]  pack_held  = '0;
  dspk_pkg::result_t           spi_bytes_due[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  logic        hold_req = 1'b0;
  logic        src_idle_on = 1'b1;
  logic        sink_idle_on = 1'b1;

  always #10 clk = ~clk;

  // Random idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Work out the SPI bytes one input word yields and queue them.
  function automatic void pack_spi_bytes(input in_word_t w);
    dspk_pkg::result_t           outs[dspk_pkg::MaxResults];
    int                          n;
    int                          ph;
    logic [dspk_pkg::PhaseW-1:0] next_phase;
    logic [31:0]                 wide;
    n = 0;
    for (int k = 0; k < dspk_pkg::MaxResults; k++) begin
      outs[k] = '0;
    end
    if (model_cfg.dc_pin_used) begin
      // Four-wire: the byte passes through and any partial nine-bit run is dropped.
      outs[0].spi_byte       = w.payload_byte;
      outs[0].dc_level       = w.is_data;
      outs[0].cs_pulse_after = w.toggle_cs_each & model_cfg.cs_pin_used;
      n = 1;
      pack_phase = '0;
      pack_held  = '0;
    end else begin
      next_phase = pack_phase + 1'b1;
      ph = int'(next_phase);
      if (next_phase == '0) begin
        // The held byte's low seven bits and this flag make one SPI byte, the payload the next.
        outs[0].spi_byte = {pack_held[dspk_pkg::ByteW-2:0], w.is_data};
        outs[1].spi_byte = w.payload_byte;
        n = 2;
      end else begin
        wide = ({24'h0, pack_held} << (9 - ph)) | ({31'h0, w.is_data} << (8 - ph))
             | ({24'h0, w.payload_byte} >> ph);
        outs[0].spi_byte = wide[dspk_pkg::ByteW-1:0];
        n = 1;
      end
      if (w.end_of_run) begin
        // Leftover bits go out zero padded, with a chip-select pulse where one exists.
        if (next_phase != '0) begin
          wide = {24'h0, w.payload_byte} << (8 - ph);
          outs[n].spi_byte       = wide[dspk_pkg::ByteW-1:0];
          outs[n].cs_pulse_after = model_cfg.cs_pin_used;
          n++;
        end
        pack_phase = '0;
        pack_held  = '0;
      end else begin
        pack_phase = next_phase;
        pack_held  = w.payload_byte;
      end
    end
    outs[n-1].last_result = 1'b1;
    for (int k = 0; k < n; k++) begin
      spi_bytes_due.push_back(outs[k]);
    end
  endfunction

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    end
  endtask

  // Monitor: register writes, accepted input words and delivered SPI bytes.
  always @(posedge clk) begin
    dspk_pkg::result_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          dspk_pkg::CfgDcPinUsed: model_cfg.dc_pin_used = cfg_ch.data;
          dspk_pkg::CfgCsPinUsed: model_cfg.cs_pin_used = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        pack_spi_bytes('{payload_byte: in_ch.payload_byte, is_data: in_ch.is_data,
                         toggle_cs_each: in_ch.toggle_cs_each, end_of_run: in_ch.end_of_run});
      end
      if (out_ch.valid && out_ch.ready) begin
        if (spi_bytes_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("SPI byte %02h arrived with no byte expected", out_ch.spi_byte);
          end
        end else begin
          want = spi_bytes_due.pop_front();
          check_field("spi_byte", want.spi_byte, out_ch.spi_byte);
          check_field("dc_level", want.dc_level, out_ch.dc_level);
          check_field("cs_pulse_after", want.cs_pulse_after, out_ch.cs_pulse_after);
          check_field("last_result", want.last_result, out_ch.last_result);
        end
      end
    end
  end

  // Receiver: random stalls, a long hold on request, or always ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LongHold;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!sink_idle_on) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one word after a random gap and wait until it is accepted; valid stays high after.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = src_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.payload_byte   <= w.payload_byte;
    in_ch.is_data        <= w.is_data;
    in_ch.toggle_cs_each <= w.toggle_cs_each;
    in_ch.end_of_run     <= w.end_of_run;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_byte(input logic [dspk_pkg::ByteW-1:0] payload, input logic is_data,
                           input logic toggle, input logic run_end);
    send_word('{payload_byte: payload, is_data: is_data, toggle_cs_each: toggle,
                end_of_run: run_end});
  endtask

  // Stop offering words and wait until every expected SPI byte has come.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (spi_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_reg(input logic [dspk_pkg::CfgIdxW-1:0] idx, input logic value);
    wait_drained();
    repeat (QuietCycles) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_word_t random_word(input logic run_end);
    in_word_t w;
    case ($urandom_range(0, 7))
      0: w.payload_byte = 8'h00;
      1: w.payload_byte = 8'hFF;
      default: w.payload_byte = 8'($urandom);
    endcase
    w.is_data        = 1'($urandom);
    w.toggle_cs_each = 1'($urandom);
    w.end_of_run     = run_end;
    return w;
  endfunction

  // Run length: mostly short, some ending exactly on a byte boundary, a few long.
  function automatic int unsigned pick_run_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return ($urandom_range(0, 1) != 0) ? 8 : 16;
    if (r < 85) return $urandom_range(1, 9);
    return $urandom_range(10, 24);
  endfunction

  // Four-wire pass-through with and without a chip select line.
  task automatic test_four_wire_pass();
    write_reg(dspk_pkg::CfgDcPinUsed, 1'b1);
    write_reg(dspk_pkg::CfgCsPinUsed, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b1, 1'b0, 1'b0);
    write_reg(dspk_pkg::CfgCsPinUsed, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b0);
  endtask

  // Three-wire framing: a run ending on a byte boundary, padded tails, an abandoned run.
  task automatic test_three_wire_framing();
    logic [dspk_pkg::ByteW-1:0] pattern[8];
    pattern = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'hFF, 8'h00};
    write_reg(dspk_pkg::CfgDcPinUsed, 1'b0);
    write_reg(dspk_pkg::CfgCsPinUsed, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_byte(pattern[i], 1'(i), 1'b0, 1'(i == 7));
    end
    send_byte(8'h81, 1'b1, 1'b1, 1'b1);
    // A run left open, then cut off by a four-wire word.
    send_byte(8'hC3, 1'b0, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    write_reg(dspk_pkg::CfgDcPinUsed, 1'b1);
    send_byte(8'h77, 1'b1, 1'b0, 1'b0);
    write_reg(dspk_pkg::CfgDcPinUsed, 1'b0);
    write_reg(dspk_pkg::CfgCsPinUsed, 1'b0);
    // Writes to unused indexes must leave both registers alone.
    write_reg(CfgIdxSpare2, 1'b1);
    write_reg(CfgIdxSpare3, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
  endtask

  // Receiver holds off while words keep coming, then the sender waits for the drain.
  task automatic test_back_pressure();
    write_reg(dspk_pkg::CfgDcPinUsed, 1'b0);
    write_reg(dspk_pkg::CfgCsPinUsed, 1'b1);
    src_idle_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_word(random_word(1'(i == 11)));
    end
    wait_drained();
    src_idle_on = 1'b1;
  endtask

  // Random runs under every register setting; the last phase runs without idling.
  task automatic test_random_runs();
    int unsigned run_len;
    int unsigned sent;
    logic        left_open;
    for (int p = 0; p < 5; p++) begin
      write_reg(dspk_pkg::CfgDcPinUsed, 1'(p == 2 || p == 3));
      write_reg(dspk_pkg::CfgCsPinUsed, 1'(p != 1 && p != 2));
      src_idle_on  = 1'(p != 4);
      sink_idle_on = 1'(p != 4);
      sent = 0;
      while (sent < PhaseItems) begin
        run_len = pick_run_len();
        left_open = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < run_len; i++) begin
          send_word(random_word(1'(i == run_len - 1) & ~left_open));
        end
        sent += run_len;
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.payload_byte   <= '0;
    in_ch.is_data        <= 1'b0;
    in_ch.toggle_cs_each <= 1'b0;
    in_ch.end_of_run     <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= dspk_pkg::CfgDcPinUsed;
    cfg_ch.data          <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_four_wire_pass();
    test_three_wire_framing();
    test_back_pressure();
    test_random_runs();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (spi_bytes_due.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dspk_pkg.sv
hw/rtl/dspk_if.sv
hw/rtl/dspk_frame.sv
hw/rtl/display_spi_nine_bit_packer.sv
sim/tb.sv
